### hw/rtl/kv_block_allocator_evict_defines.svh
// Assertion macros for the block allocator.
`ifndef KV_BLOCK_ALLOCATOR_EVICT_DEFINES_SVH
`define KV_BLOCK_ALLOCATOR_EVICT_DEFINES_SVH
`define KVBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvba check failed");
`define KVBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvba check failed");
`endif

### hw/rtl/kvba_pkg.sv
// Shared types and constants of the block allocator.
package kvba_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEQ,
    ST_RDB,
    ST_SCAN,
    ST_MUL,
    ST_WB
  } kvba_state_t;

  typedef enum logic [1:0] {
    POL_LRU   = 2'd0,
    POL_SLIDE = 2'd1,
    POL_LFU   = 2'd2,
    POL_COST  = 2'd3
  } kvba_policy_t;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_TPB    = 2'd1;
  localparam logic [1:0] CFG_DECAY  = 2'd2;

  localparam int          SCORE_W     = 32;
  localparam int          DECAY_W     = 17;
  localparam int          STAMP_W     = 48;
  localparam logic [16:0] DECAY_ONE   = 17'd65536;
  localparam logic [16:0] DECAY_RST   = 17'd58982;
  localparam logic [8:0]  TPB_RST     = 9'd16;
endpackage

### hw/rtl/kv_block_allocator_evict.sv
// Top level: token block allocator with LRU (also used for the slide policy), LFU and cost eviction.
// Path: start, then ST_SEQ, ST_RDB (partly filled block only), ST_SCAN (victim search only),
//   ST_MUL, ST_WB, then registered out_valid; the scan reads one block-memory entry per cycle.
// Throughput: one item at a time; busy stays high until the result beat is issued.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears control state, config and seq-table valid bits at once; no clearing pass.
`include "kv_block_allocator_evict_defines.svh"
module kv_block_allocator_evict #(
  parameter int NUM_BLOCKS       = 64,
  parameter int NUM_SEQS         = 16,
  parameter int MAX_BLOCK_TOKENS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_seq_id,
  output logic        out_valid,
  output logic [5:0]  out_block_index,
  output logic [7:0]  out_slot_offset,
  output logic        out_new_block,
  output logic        out_evicted,
  output logic [3:0]  out_evicted_owner,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import kvba_pkg::*;

  localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNW = $clog2(NUM_BLOCKS + 1);
  localparam int SW  = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
  localparam int FW  = (MAX_BLOCK_TOKENS > 1) ? $clog2(MAX_BLOCK_TOKENS) : 1;
  localparam int TW  = $clog2(MAX_BLOCK_TOKENS + 1);
  localparam int CW  = (TW > 9) ? TW : 9;

  typedef logic [SW-1:0] seq_map_t [16];

  function automatic seq_map_t build_map();
    seq_map_t m;
    for (int i = 0; i < 16; i++) begin
      m[i] = SW'(i % NUM_SEQS);
    end
    return m;
  endfunction

  localparam seq_map_t SEQ_MAP = build_map();

  typedef struct packed {
    logic [SW-1:0]      owner;
    logic [31:0]        freq;
    logic [31:0]        cost;
    logic [STAMP_W-1:0] stamp;
  } bent_t;

  logic [1:0]         policy_r;
  logic [8:0]         tpb_r;
  logic [16:0]        decay_r;

  kvba_state_t        state_r, state_nxt;
  logic [SW-1:0]      seq_r, seq_nxt;
  logic [AW-1:0]      blk_r, blk_nxt;
  logic [SW-1:0]      owner_r, owner_nxt;
  logic [31:0]        freq_r, freq_nxt;
  logic [31:0]        cost_r, cost_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               new_r, new_nxt;
  logic               ev_r, ev_nxt;
  logic [SW-1:0]      evown_r, evown_nxt;
  logic [CNW-1:0]     alloc_cnt_r, alloc_cnt_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [CNW-1:0]     scan_idx_r, scan_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               best_vld_r, best_vld_nxt;
  logic [STAMP_W-1:0] best_key_r, best_key_nxt;
  logic [AW-1:0]      best_idx_r, best_idx_nxt;
  logic [SW-1:0]      best_own_r, best_own_nxt;

  logic               out_valid_r;
  logic [5:0]         out_blk_r;
  logic [7:0]         out_slot_r;
  logic               out_new_r;
  logic               out_ev_r;
  logic [3:0]         out_evown_r;

  bent_t              bmem [NUM_BLOCKS];
  bent_t              bm_rd_r;
  bent_t              bm_wr;
  logic               bm_rd_en;
  logic [AW-1:0]      bm_rd_addr;
  logic               bm_wr_en;

  logic               sq_rd_en;
  logic [AW-1:0]      sq_cur;
  logic [FW-1:0]      sq_fill;
  logic               sq_wr_en;
  logic [FW-1:0]      sq_wr_fill;

  logic               mul_en;
  logic [31:0]        freq_dec;
  logic [31:0]        cost_dec;
  logic [31:0]        freq_w;
  logic [31:0]        cost_w;
  logic [CW-1:0]      tpb_eff;
  logic [CW-1:0]      fill_inc;
  logic [STAMP_W-1:0] scan_key;
  logic               accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 2'(POL_LRU);
      tpb_r    <= TPB_RST;
      decay_r  <= DECAY_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_POLICY: policy_r <= cfg_wdata[1:0];
        CFG_TPB:    tpb_r    <= cfg_wdata[8:0];
        CFG_DECAY:  decay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kvba_seq_table #(
    .NUM_SEQS (NUM_SEQS),
    .SW       (SW),
    .AW       (AW),
    .FW       (FW)
  ) u_seq_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (sq_rd_en),
    .rd_addr (SEQ_MAP[in_seq_id]),
    .rd_cur  (sq_cur),
    .rd_fill (sq_fill),
    .wr_en   (sq_wr_en),
    .wr_addr (seq_r),
    .wr_cur  (blk_r),
    .wr_fill (sq_wr_fill)
  );

  kvba_score_unit u_score_unit (
    .clk     (clk),
    .en      (mul_en),
    .freq_i  (freq_r),
    .cost_i  (cost_r),
    .decay_i (decay_r),
    .freq_o  (freq_dec),
    .cost_o  (cost_dec)
  );

  always_ff @(posedge clk) begin
    if (bm_wr_en) begin
      bmem[blk_r] <= bm_wr;
    end
    if (bm_rd_en) begin
      bm_rd_r <= bmem[bm_rd_addr];
    end
  end

  assign tpb_eff = ((tpb_r == 9'd0) || (CW'(tpb_r) > CW'(MAX_BLOCK_TOKENS)))
                   ? CW'(MAX_BLOCK_TOKENS) : CW'(tpb_r);
  assign fill_inc   = CW'(fill_r) + CW'(1);
  assign sq_wr_fill = (fill_inc >= tpb_eff) ? '0 : FW'(fill_inc);

  assign freq_w = (policy_r == 2'(POL_LFU) || policy_r == 2'(POL_COST)) ? freq_dec : freq_r;
  assign cost_w = (policy_r == 2'(POL_COST)) ? cost_dec : cost_r;
  assign bm_wr  = '{owner: owner_r, freq: freq_w, cost: cost_w, stamp: stamp_r};

  always_comb begin
    unique case (policy_r)
      2'(POL_LFU):  scan_key = STAMP_W'(bm_rd_r.freq);
      2'(POL_COST): scan_key = STAMP_W'(bm_rd_r.cost);
      default:      scan_key = bm_rd_r.stamp;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SEQ;
      ST_SEQ: begin
        if (sq_fill != '0) begin
          state_nxt = ST_RDB;
        end else if (alloc_cnt_r < CNW'(NUM_BLOCKS)) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RDB: state_nxt = ST_MUL;
      ST_SCAN: if (scan_idx_r == CNW'(NUM_BLOCKS) && !cmp_vld_r) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WB;
      ST_WB: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != ST_IDLE);
    sq_rd_en   = accept;
    sq_wr_en   = (state_r == ST_WB);
    bm_wr_en   = (state_r == ST_WB);
    mul_en     = (state_r == ST_MUL);
    bm_rd_en   = 1'b0;
    bm_rd_addr = sq_cur;
    unique case (state_r)
      ST_SEQ: bm_rd_en = 1'b1;
      ST_SCAN: begin
        bm_rd_en   = (scan_idx_r < CNW'(NUM_BLOCKS));
        bm_rd_addr = AW'(scan_idx_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    seq_nxt       = seq_r;
    blk_nxt       = blk_r;
    owner_nxt     = owner_r;
    freq_nxt      = freq_r;
    cost_nxt      = cost_r;
    fill_nxt      = fill_r;
    new_nxt       = new_r;
    ev_nxt        = ev_r;
    evown_nxt     = evown_r;
    alloc_cnt_nxt = alloc_cnt_r;
    stamp_nxt     = stamp_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_vld_nxt  = best_vld_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    best_own_nxt  = best_own_r;
    unique case (state_r)
      ST_IDLE: if (start) seq_nxt = SEQ_MAP[in_seq_id];
      ST_SEQ: begin
        fill_nxt  = sq_fill;
        ev_nxt    = 1'b0;
        evown_nxt = '0;
        if (sq_fill != '0) begin
          blk_nxt = sq_cur;
          new_nxt = 1'b0;
        end else begin
          new_nxt      = 1'b1;
          owner_nxt    = seq_r;
          freq_nxt     = '0;
          cost_nxt     = '0;
          blk_nxt      = AW'(alloc_cnt_r);
          scan_idx_nxt = '0;
          best_vld_nxt = 1'b0;
        end
      end
      ST_RDB: begin
        owner_nxt = bm_rd_r.owner;
        freq_nxt  = bm_rd_r.freq;
        cost_nxt  = bm_rd_r.cost;
      end
      ST_SCAN: begin
        if (scan_idx_r < CNW'(NUM_BLOCKS)) begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = AW'(scan_idx_r);
          scan_idx_nxt = scan_idx_r + CNW'(1);
        end
        if (cmp_vld_r && (!best_vld_r || scan_key < best_key_r)) begin
          best_vld_nxt = 1'b1;
          best_key_nxt = scan_key;
          best_idx_nxt = cmp_idx_r;
          best_own_nxt = bm_rd_r.owner;
        end
        if (scan_idx_r == CNW'(NUM_BLOCKS) && !cmp_vld_r) begin
          blk_nxt   = best_idx_r;
          ev_nxt    = 1'b1;
          evown_nxt = best_own_r;
        end
      end
      ST_WB: begin
        stamp_nxt = stamp_r + STAMP_W'(1);
        if (new_r && !ev_r) alloc_cnt_nxt = alloc_cnt_r + CNW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alloc_cnt_r <= '0;
      stamp_r     <= '0;
      cmp_vld_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      stamp_r     <= stamp_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= (state_r == ST_WB);
    end
  end

  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    blk_r      <= blk_nxt;
    owner_r    <= owner_nxt;
    freq_r     <= freq_nxt;
    cost_r     <= cost_nxt;
    fill_r     <= fill_nxt;
    new_r      <= new_nxt;
    ev_r       <= ev_nxt;
    evown_r    <= evown_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_key_r <= best_key_nxt;
    best_idx_r <= best_idx_nxt;
    best_own_r <= best_own_nxt;
    if (state_r == ST_WB) begin
      out_blk_r   <= 6'(blk_r);
      out_slot_r  <= 8'(fill_r);
      out_new_r   <= new_r;
      out_ev_r    <= ev_r;
      out_evown_r <= 4'(evown_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_index   = out_blk_r;
  assign out_slot_offset   = out_slot_r;
  assign out_new_block     = out_new_r;
  assign out_evicted       = out_ev_r;
  assign out_evicted_owner = out_evown_r;

  `KVBA_ASSERT_NEXT(a_one_beat, out_valid_r, !out_valid_r)
  `KVBA_ASSERT_IMPL(a_evict_is_new, out_valid_r && out_ev_r, out_new_r)
  `KVBA_ASSERT_NEXT(a_accept_busy, accept, busy)
  `KVBA_ASSERT_IMPL(a_evict_full, out_valid_r && out_ev_r, alloc_cnt_r == CNW'(NUM_BLOCKS))
endmodule

### hw/rtl/kvba_seq_table.sv
// Per-sequence current block and fill count, registered read.
module kvba_seq_table #(
  parameter int NUM_SEQS = 16,
  parameter int SW       = 4,
  parameter int AW       = 6,
  parameter int FW       = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [AW-1:0] rd_cur,
  output logic [FW-1:0] rd_fill,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [AW-1:0] wr_cur,
  input  logic [FW-1:0] wr_fill
);
  logic [AW+FW-1:0]   mem [NUM_SEQS];
  logic [NUM_SEQS-1:0] vld_r;
  logic [AW+FW-1:0]   rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cur, wr_fill};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_cur  = rd_vld_r ? rd_data_r[AW+FW-1:FW] : '0;
  assign rd_fill = rd_vld_r ? rd_data_r[FW-1:0] : '0;
endmodule

### hw/rtl/kvba_score_unit.sv
// Score decay: registered products, then add one and saturate.
module kvba_score_unit (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] freq_i,
  input  logic [31:0] cost_i,
  input  logic [16:0] decay_i,
  output logic [31:0] freq_o,
  output logic [31:0] cost_o
);
  import kvba_pkg::*;

  logic [16:0] dcl;
  logic [48:0] prod_f_r;
  logic [48:0] prod_c_r;
  logic [33:0] sum_f;
  logic [33:0] sum_c;

  assign dcl = (decay_i > DECAY_ONE) ? DECAY_ONE : decay_i;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_f_r <= 49'(freq_i) * 49'(dcl);
      prod_c_r <= 49'(cost_i) * 49'(dcl);
    end
  end

  assign sum_f  = {1'b0, prod_f_r[48:16]} + 34'd65536;
  assign sum_c  = {1'b0, prod_c_r[48:16]} + 34'd65536;
  assign freq_o = (sum_f[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_f[31:0];
  assign cost_o = (sum_c[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_c[31:0];
endmodule

### tb/kv_block_allocator_evict_tb.sv
// Testbench for the token block allocator: directed table plus random traffic, scored by a predictor.
module kv_block_allocator_evict_tb;
  import kvba_pkg::*;

  localparam int NB = 64;
  localparam int NS = 16;
  localparam int MAXT = 256;

  typedef struct packed {
    logic [5:0] blk;
    logic [7:0] slot;
    logic       nb;
    logic       ev;
    logic [3:0] owner;
  } alloc_t;

  typedef struct {
    logic [3:0] seq;
    logic       chk;
    alloc_t     res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic [3:0] in_seq_id = '0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_POLICY;
  logic [16:0] cfg_wdata = '0;
  logic busy, out_valid, out_new_block, out_evicted;
  logic [5:0] out_block_index;
  logic [7:0] out_slot_offset;
  logic [3:0] out_evicted_owner;

  kv_block_allocator_evict dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [1:0]  m_pol;
  logic [8:0]  m_tpb;
  logic [16:0] m_decay;
  bit          m_used[NB];
  logic [3:0]  m_owner[NB];
  int          m_lru[$];
  logic [31:0] m_freq[NB];
  logic [31:0] m_cost[NB];
  logic [5:0]  m_cur[NS];
  int          m_fill[NS];

  alloc_t pending_allocs[$];
  int errors = 0;
  int send_idle = 18;

  function automatic void model_reset();
    m_pol = POL_LRU; m_tpb = TPB_RST; m_decay = DECAY_RST;
    m_lru = {};
    for (int i = 0; i < NB; i++) begin
      m_used[i] = 0; m_owner[i] = 0; m_freq[i] = 0; m_cost[i] = 0;
    end
    for (int i = 0; i < NS; i++) begin
      m_cur[i] = 0; m_fill[i] = 0;
    end
  endfunction

  function automatic void touch_mru(int b);
    foreach (m_lru[i]) if (m_lru[i] == b) begin
      m_lru.delete(i);
      break;
    end
    m_lru.insert(m_lru.size(), b);
  endfunction

  function automatic logic [31:0] decayed(logic [31:0] s);
    logic [63:0] d, p;
    d = (m_decay > DECAY_ONE) ? 64'(DECAY_ONE) : 64'(m_decay);
    p = ((64'(s) * d) >> 16) + 64'd65536;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic alloc_t place_token(logic [3:0] seq);
    alloc_t r;
    int tpb, b, best;
    logic [31:0] sc, bsc;
    r = '0;
    tpb = (m_tpb == 0 || m_tpb > MAXT) ? MAXT : int'(m_tpb);
    if (m_fill[seq] == 0) begin
      b = NB;
      for (int i = 0; i < NB; i++) if (!m_used[i]) begin
        b = i;
        break;
      end
      if (b == NB) begin
        best = NB; bsc = 0;
        if (m_pol == POL_LRU || m_pol == POL_SLIDE) begin
          if (m_lru.size() > 0) best = m_lru[0];
        end else begin
          for (int i = 0; i < NB; i++) if (m_used[i]) begin
            sc = (m_pol == POL_LFU) ? m_freq[i] : m_cost[i];
            if (best == NB || sc < bsc) begin
              best = i; bsc = sc;
            end
          end
        end
        if (best < NB) begin
          b = best; r.ev = 1; r.owner = m_owner[b];
        end else b = 0;
      end
      m_used[b] = 1; m_owner[b] = seq; touch_mru(b);
      m_freq[b] = 0; m_cost[b] = 0; m_cur[seq] = 6'(b); r.nb = 1;
    end
    b = int'(m_cur[seq]);
    r.blk = 6'(b);
    r.slot = 8'(m_fill[seq]);
    m_fill[seq]++;
    if (m_pol == POL_LFU || m_pol == POL_COST) begin
      m_freq[b] = decayed(m_freq[b]);
      if (m_pol == POL_COST) m_cost[b] = decayed(m_cost[b]);
    end
    touch_mru(b);
    if (m_fill[seq] >= tpb) m_fill[seq] = 0;
    return r;
  endfunction

  // start stays high after an accept only when the next beat follows at once
  task automatic send_token(logic [3:0] seq, bit chk, alloc_t want);
    alloc_t p;
    while ($urandom_range(99) < send_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_seq_id <= seq;
    do @(posedge clk); while (busy);
    p = place_token(seq);
    if (chk && p !== want) begin
      $display("%0t table row mismatch: expected %p actual %p", $realtime, want, p);
      errors++;
    end
    pending_allocs.insert(pending_allocs.size(), p);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    start <= 0;
    while (pending_allocs.size() > 0) @(posedge clk);
    repeat (NB + 10) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_POLICY: m_pol = val[1:0];
      CFG_TPB:    m_tpb = val[8:0];
      CFG_DECAY:  m_decay = val;
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_block_index, out_slot_offset, out_new_block, out_evicted,
              out_evicted_owner};
      if (pending_allocs.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $realtime, got);
        errors++;
      end else begin
        want = pending_allocs[0];
        pending_allocs.delete(0);
        if (got.blk !== want.blk) begin
          $display("%0t block_index: expected %0d actual %0d", $realtime, want.blk, got.blk);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t slot_offset: expected %0d actual %0d", $realtime, want.slot, got.slot);
          errors++;
        end
        if (got.nb !== want.nb) begin
          $display("%0t new_block: expected %0d actual %0d", $realtime, want.nb, got.nb);
          errors++;
        end
        if (got.ev !== want.ev) begin
          $display("%0t evicted: expected %0d actual %0d", $realtime, want.ev, got.ev);
          errors++;
        end
        if (got.owner !== want.owner) begin
          $display("%0t evicted_owner: expected %0d actual %0d", $realtime, want.owner,
                   got.owner);
          errors++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t tbl[$];
    logic [1:0] pols[4];
    logic [8:0] tpbs[6];
    logic [16:0] decays[6];
    int n;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults after reset, extreme seqs
    tbl.insert(tbl.size(), '{4'd0,  1, '{6'd0, 8'd0, 1'b1, 1'b0, 4'd0}});
    tbl.insert(tbl.size(), '{4'd0,  1, '{6'd0, 8'd1, 1'b0, 1'b0, 4'd0}});
    tbl.insert(tbl.size(), '{4'd15, 1, '{6'd1, 8'd0, 1'b1, 1'b0, 4'd0}});
    tbl.insert(tbl.size(), '{4'd15, 1, '{6'd1, 8'd1, 1'b0, 1'b0, 4'd0}});
    tbl.insert(tbl.size(), '{4'd5,  1, '{6'd2, 8'd0, 1'b1, 1'b0, 4'd0}});
    tbl.insert(tbl.size(), '{4'd10, 0, '0});
    tbl.insert(tbl.size(), '{4'd0,  0, '0});
    foreach (tbl[i]) send_token(tbl[i].seq, tbl[i].chk, tbl[i].res);

    // block size zero and oversized act as maximum; shrink mid-block
    write_reg(CFG_TPB, 17'd0);
    for (int i = 0; i < 3; i++) send_token(4'd3, 0, '0);
    write_reg(CFG_TPB, 17'h1FF);
    send_token(4'd3, 0, '0);
    write_reg(CFG_TPB, 17'd1);
    send_token(4'd3, 0, '0);
    send_token(4'd3, 0, '0);

    // fill all blocks with single-token blocks, then evict under each policy
    write_reg(CFG_DECAY, 17'h1FFFF);
    write_reg(CFG_POLICY, 17'(POL_COST));
    for (int i = 0; i < 70; i++) send_token(4'($urandom_range(15)), 0, '0);

    pols = '{POL_LRU, POL_SLIDE, POL_LFU, POL_COST};
    tpbs = '{9'd1, 9'd2, 9'd3, 9'd256, 9'd0, 9'd300};
    decays = '{17'd0, 17'd65536, 17'h1FFFF, 17'd58982, 17'd1, 17'd32768};
    for (int ph = 0; ph < 12; ph++) begin
      send_idle = (ph < 4) ? 18 : (ph < 8) ? 83 : 0;
      write_reg(CFG_POLICY, 17'(pols[ph % 4]));
      write_reg(CFG_TPB, 17'(tpbs[$urandom_range(5)] | ($urandom_range(1) << 9)));
      write_reg(CFG_DECAY, 17'(decays[$urandom_range(5)]) ^ 17'($urandom_range(1) << 16));
      n = 30;
      for (int i = 0; i < n; i++) begin
        // mostly a few hot sequences, so blocks fill and scores build up
        if ($urandom_range(3) != 0) send_token(4'($urandom_range(3)), 0, '0);
        else send_token(4'($urandom), 0, '0);
      end
    end

    start <= 0;
    while (pending_allocs.size() > 0) @(posedge clk);
    repeat (NB + 10) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/kvba_pkg.sv
hw/rtl/kvba_seq_table.sv
hw/rtl/kvba_score_unit.sv
hw/rtl/kv_block_allocator_evict.sv
tb/kv_block_allocator_evict_tb.sv
